@@ design/spot_pkg.sv @@
package spot_pkg;

  // Radius fields are fixed at Q14.4 whatever the coordinate width
  localparam int RADIUS_W = 18;
  // Operands of the squaring stage: doubled radius or radius sum
  localparam int SQ_W     = RADIUS_W + 1;
  localparam int SQR_W    = 2 * SQ_W;

  typedef enum logic [1:0] {
    MODE_RECT_RECT     = 2'd0,
    MODE_RECT_CIRCLE   = 2'd1,
    MODE_CIRCLE_CIRCLE = 2'd2,
    MODE_NONE          = 2'd3
  } spot_mode_t;

  // Prepared pair: either already decided, or left to the corner/distance test
  typedef struct packed {
    logic            decided;
    logic            early_hit;
    logic [SQ_W-1:0] ea;
    logic [SQ_W-1:0] eb;
    logic [SQ_W-1:0] lim;
  } spot_req_t;

  typedef struct packed {
    logic             decided;
    logic             early_hit;
    logic [SQR_W-1:0] ea2;
    logic [SQR_W-1:0] eb2;
    logic [SQR_W-1:0] lim2;
  } spot_sq_t;

endpackage

@@ design/spot_in_if.sv @@
interface spot_in_if #(
  parameter int COORD_WIDTH = 20
);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic                              eligible;
  logic signed [COORD_WIDTH-1:0]     first_left;
  logic signed [COORD_WIDTH-1:0]     first_top;
  logic signed [COORD_WIDTH-1:0]     first_right;
  logic signed [COORD_WIDTH-1:0]     first_bottom;
  logic signed [COORD_WIDTH-1:0]     second_left;
  logic signed [COORD_WIDTH-1:0]     second_top;
  logic signed [COORD_WIDTH-1:0]     second_right;
  logic signed [COORD_WIDTH-1:0]     second_bottom;
  logic [spot_pkg::RADIUS_W-1:0]     first_radius;
  logic [spot_pkg::RADIUS_W-1:0]     second_radius;

  modport source (
    output valid, mode, eligible,
    output first_left, first_top, first_right, first_bottom,
    output second_left, second_top, second_right, second_bottom,
    output first_radius, second_radius,
    input  ready
  );

  modport sink (
    input  valid, mode, eligible,
    input  first_left, first_top, first_right, first_bottom,
    input  second_left, second_top, second_right, second_bottom,
    input  first_radius, second_radius,
    output ready
  );
endinterface

@@ design/spot_out_if.sv @@
interface spot_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

@@ design/spot_prep.sv @@
module spot_prep #(
  parameter int COORD_WIDTH = 20
) (
  input  logic [1:0]                          mode,
  input  logic                                eligible,
  input  logic signed [COORD_WIDTH-1:0]       first_left,
  input  logic signed [COORD_WIDTH-1:0]       first_top,
  input  logic signed [COORD_WIDTH-1:0]       first_right,
  input  logic signed [COORD_WIDTH-1:0]       first_bottom,
  input  logic signed [COORD_WIDTH-1:0]       second_left,
  input  logic signed [COORD_WIDTH-1:0]       second_top,
  input  logic signed [COORD_WIDTH-1:0]       second_right,
  input  logic signed [COORD_WIDTH-1:0]       second_bottom,
  input  logic [spot_pkg::RADIUS_W-1:0]       first_radius,
  input  logic [spot_pkg::RADIUS_W-1:0]       second_radius,
  output spot_pkg::spot_req_t                 req
);

  // Working width: room for doubled coordinates, sums and sign
  localparam int EW = ((COORD_WIDTH > spot_pkg::SQ_W) ? COORD_WIDTH : spot_pkg::SQ_W) + 4;
  localparam int RPAD = EW - spot_pkg::RADIUS_W;

  logic signed [EW-1:0] l1_e, t1_e, r1_e, b1_e, l2_e, t2_e;
  logic signed [EW-1:0] ra_e, rb_e;
  logic signed [EW-1:0] ddx, ddy, dx2, dy2, w_e, h_e, rad2_e, ex_e, ey_e;
  logic signed [EW-1:0] cdx, cdy, adx, ady, sum_e;
  logic                 rr_hit, rc_out, rc_in, cc_out;

  assign l1_e = EW'(first_left);
  assign t1_e = EW'(first_top);
  assign r1_e = EW'(first_right);
  assign b1_e = EW'(first_bottom);
  assign l2_e = EW'(second_left);
  assign t2_e = EW'(second_top);
  assign ra_e = $signed({{RPAD{1'b0}}, first_radius});
  assign rb_e = $signed({{RPAD{1'b0}}, second_radius});

  // Rect-rect: both non-empty and strict overlap on both axes
  assign rr_hit = (first_right > first_left) && (first_bottom > first_top) &&
                  (second_right > second_left) && (second_bottom > second_top) &&
                  (first_right > second_left) && (second_right > first_left) &&
                  (first_bottom > second_top) && (second_bottom > first_top);

  // Rect-circle on doubled distances from the box centre
  assign ddx    = (l2_e <<< 1) - (l1_e + r1_e);
  assign ddy    = (t2_e <<< 1) - (t1_e + b1_e);
  assign dx2    = ddx[EW-1] ? -ddx : ddx;
  assign dy2    = ddy[EW-1] ? -ddy : ddy;
  assign w_e    = r1_e - l1_e;
  assign h_e    = b1_e - t1_e;
  assign rad2_e = rb_e <<< 1;
  assign rc_out = (dx2 > w_e + rad2_e) || (dy2 > h_e + rad2_e);
  assign rc_in  = (dx2 <= w_e) || (dy2 <= h_e);
  assign ex_e   = dx2 - w_e;
  assign ey_e   = dy2 - h_e;

  // Circle-circle
  assign cdx    = l2_e - l1_e;
  assign cdy    = t2_e - t1_e;
  assign adx    = cdx[EW-1] ? -cdx : cdx;
  assign ady    = cdy[EW-1] ? -cdy : cdy;
  assign sum_e  = ra_e + rb_e;
  assign cc_out = (adx > sum_e) || (ady > sum_e);

  // Operands are only used when the box test passed, so they fit SQ_W
  always_comb begin
    req.decided   = 1'b1;
    req.early_hit = 1'b0;
    req.ea        = ex_e[spot_pkg::SQ_W-1:0];
    req.eb        = ey_e[spot_pkg::SQ_W-1:0];
    req.lim       = rad2_e[spot_pkg::SQ_W-1:0];
    if (eligible) begin
      unique case (spot_pkg::spot_mode_t'(mode))
        spot_pkg::MODE_RECT_RECT: begin
          req.early_hit = rr_hit;
        end
        spot_pkg::MODE_RECT_CIRCLE: begin
          req.decided   = rc_out || rc_in;
          req.early_hit = !rc_out && rc_in;
        end
        spot_pkg::MODE_CIRCLE_CIRCLE: begin
          req.decided = cc_out;
          req.ea      = adx[spot_pkg::SQ_W-1:0];
          req.eb      = ady[spot_pkg::SQ_W-1:0];
          req.lim     = sum_e[spot_pkg::SQ_W-1:0];
        end
        spot_pkg::MODE_NONE: begin
          req.early_hit = 1'b0;
        end
        default: begin
          req.early_hit = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ design/spot_square.sv @@
module spot_square (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spot_pkg::spot_req_t req,
  output logic                out_valid,
  input  logic                out_ready,
  output spot_pkg::spot_sq_t  sq
);

  logic               valid_r;
  spot_pkg::spot_sq_t sq_r, sq_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign sq        = sq_r;

  always_comb begin
    sq_nxt.decided   = req.decided;
    sq_nxt.early_hit = req.early_hit;
    sq_nxt.ea2       = spot_pkg::SQR_W'(req.ea * req.ea);
    sq_nxt.eb2       = spot_pkg::SQR_W'(req.eb * req.eb);
    sq_nxt.lim2      = spot_pkg::SQR_W'(req.lim * req.lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

@@ design/shape_pair_overlap_test.sv @@
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    mode, eligible, edges of both boxes (COORD_WIDTH), both radii (RADIUS_W)
// out_ch   out  valid/ready    hit
//
// One transaction per cycle sustained while out_ch is not stalled; the result
// passes input reg -> prepare reg -> square reg -> result reg before it is offered.
// The squaring stage's three 19x19 multipliers set the stage split.
// rst_n is synchronous, active low, and empties every stage.
// A stall on out_ch holds the result; in_ch keeps accepting until every
// stage is full (four transactions in flight), then ready drops.
module shape_pair_overlap_test #(
  parameter int COORD_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  spot_in_if.sink     in_ch,
  spot_out_if.source  out_ch
);

  // Stage 1: input register
  logic                                s1_valid_r;
  logic                                s1_ready;
  logic [1:0]                          mode_r;
  logic                                eligible_r;
  logic signed [COORD_WIDTH-1:0]       first_left_r, first_top_r;
  logic signed [COORD_WIDTH-1:0]       first_right_r, first_bottom_r;
  logic signed [COORD_WIDTH-1:0]       second_left_r, second_top_r;
  logic signed [COORD_WIDTH-1:0]       second_right_r, second_bottom_r;
  logic [spot_pkg::RADIUS_W-1:0]       first_radius_r, second_radius_r;

  // Stage 2: prepared pair
  logic                                s2_valid_r;
  logic                                s2_ready;
  logic                                s2_load;
  spot_pkg::spot_req_t                 req_nxt, req_r;

  // Stage 3: squares (inside spot_square)
  logic                                sq_valid;
  spot_pkg::spot_sq_t                  sq;

  // Stage 4: result register
  logic                                out_valid_r;
  logic                                out_stage_ready;
  logic                                hit_r, hit_nxt;
  logic [spot_pkg::SQR_W:0]            dist2;

  // Ready ripples back; any empty stage lets the stages before it advance
  assign out_stage_ready = !out_valid_r || out_ch.ready;
  assign s2_load         = !s2_valid_r || s2_ready;
  assign s1_ready        = !s1_valid_r || s2_load;
  assign in_ch.ready     = s1_ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_stage_ready) begin
        out_valid_r <= sq_valid;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      mode_r          <= in_ch.mode;
      eligible_r      <= in_ch.eligible;
      first_left_r    <= in_ch.first_left;
      first_top_r     <= in_ch.first_top;
      first_right_r   <= in_ch.first_right;
      first_bottom_r  <= in_ch.first_bottom;
      second_left_r   <= in_ch.second_left;
      second_top_r    <= in_ch.second_top;
      second_right_r  <= in_ch.second_right;
      second_bottom_r <= in_ch.second_bottom;
      first_radius_r  <= in_ch.first_radius;
      second_radius_r <= in_ch.second_radius;
    end
    if (s2_load && s1_valid_r) begin
      req_r <= req_nxt;
    end
    if (out_stage_ready && sq_valid) begin
      hit_r <= hit_nxt;
    end
  end

  // Box tests, empty checks and selection of the squaring operands
  spot_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .mode          (mode_r),
    .eligible      (eligible_r),
    .first_left    (first_left_r),
    .first_top     (first_top_r),
    .first_right   (first_right_r),
    .first_bottom  (first_bottom_r),
    .second_left   (second_left_r),
    .second_top    (second_top_r),
    .second_right  (second_right_r),
    .second_bottom (second_bottom_r),
    .first_radius  (first_radius_r),
    .second_radius (second_radius_r),
    .req           (req_nxt)
  );

  spot_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_ready  (s2_ready),
    .req       (req_r),
    .out_valid (sq_valid),
    .out_ready (out_stage_ready),
    .sq        (sq)
  );

  // Corner or centre distance: sum of squares against squared limit
  assign dist2   = {1'b0, sq.ea2} + {1'b0, sq.eb2};
  assign hit_nxt = sq.decided ? sq.early_hit : (dist2 <= {1'b0, sq.lim2});

endmodule

@@ design/spot_checker.sv @@
module spot_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // A pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hit_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("hit changed while stalled");

  // A draining output must never block the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // With out_ready held high after acceptance, the result must be offered once it has passed the stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result late");

endmodule

bind shape_pair_overlap_test spot_checker u_spot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);
